/* rtl/pcpm_pkg.sv */
// Shared widths and controller/datapath interface types for the
// per-channel positive mean block. No dependencies.
`default_nettype none

package pcpm_pkg;

  localparam int CH_W     = 6;   // channel field
  localparam int SAMPLE_W = 16;  // signed Q8.8 sample
  localparam int AVG_W    = 15;  // unsigned Q7.8 average
  localparam int CFG_W    = 7;   // channels_in_use register
  localparam int SUM_W    = 27;  // per-channel sum
  localparam int CNT_W    = 13;  // per-channel count
  localparam int RES_CAP  = 64;  // most results one emit can give

  typedef enum logic {
    ACT_ACCUM = 1'b0,
    ACT_EMIT  = 1'b1
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_load;     // capture sample, read its channel entry
    logic acc_write;    // write updated sum and count
    logic emit_read;    // read entry at the emit index
    logic div_start;    // launch division on the entry just read
    logic res_load;     // present a data result
    logic nodata_load;  // present the no-data result
    logic idx_clear;
    logic idx_inc;
    logic clear_all;    // drop every entry and the loaded flag
  } pcpm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_loaded;
    logic div_done;
    logic idx_last;
  } pcpm_sts_t;

endpackage

`default_nettype wire

/* rtl/per_channel_positive_mean.sv */
// Top level of the per-channel positive mean block: controller plus
// datapath. Depends on pcpm_pkg, pcpm_ctrl and pcpm_datapath.
`default_nettype none

// Usage
//   Commands: an item transfers on a rising edge with start_i high and
//   busy_o low. action_i = 0 accumulates sample_i (signed Q8.8), if positive, on
//   channel_i; action_i = 1 emits the averages and clears every channel.
//   An accumulate is one store read followed by one store write.
//   An emit with no samples since the last emit gives a single no_data
//   result in the cycle after the transfer and does not raise busy_o.
//   Otherwise an emit walks the channels in use in order; per channel it
//   does a store read, an operand load and a bit-serial divide, and it
//   gives one result per channel, last_o on the final one.
//   Results: result_valid_o strobes for one cycle per result; the
//   receiver cannot hold results off, so every strobe is a transfer.
//   Configuration: cfg_valid_i/cfg_ready_o transfers channels_in_use;
//   cfg_ready_o is always high. Write it only while idle.
//   Reset: rst_ni clears the channel valid bits, the loaded flag and the
//   controller at once; channels_in_use returns to 1. No clearing pass.
module per_channel_positive_mean_core #(
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic                                 action_i,
  input  wire logic [pcpm_pkg::CH_W-1:0]            channel_i,
  input  wire logic signed [pcpm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [pcpm_pkg::CFG_W-1:0]           cfg_data_i,
  output logic                                      result_valid_o,
  output logic      [pcpm_pkg::CH_W-1:0]            out_channel_o,
  output logic      [pcpm_pkg::AVG_W-1:0]           average_o,
  output logic                                      no_data_o,
  output logic                                      last_o
);

  import pcpm_pkg::*;

  pcpm_cmd_t cmd;
  pcpm_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcpm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  pcpm_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .out_channel_o  (out_channel_o),
    .average_o      (average_o),
    .no_data_o      (no_data_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

/* rtl/pcpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcpm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/pcpm_div.sv */
// Restoring divider, one quotient bit per cycle, for sum / count.
// Depends on pcpm_pkg for the operand widths.
`default_nettype none

module pcpm_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pcpm_pkg::SUM_W-1:0] dividend_i,
  input  wire logic [pcpm_pkg::CNT_W-1:0] divisor_i,
  output logic                           done_o,
  output logic      [pcpm_pkg::SUM_W-1:0] quotient_o
);

  import pcpm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              run_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              done_q;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign fits     = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(SUM_W);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      // shift in the next dividend bit; subtract when it fits
      rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/pcpm_datapath.sv */
// Datapath: channel store RAM with valid bits, accumulate update, divider,
// configuration register and result registers. Depends on pcpm_pkg,
// pcpm_ram and pcpm_div.
`default_nettype none

module pcpm_datapath #(
  parameter int MAX_CHANNELS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pcpm_pkg::pcpm_cmd_t           cmd_i,
  output pcpm_pkg::pcpm_sts_t                sts_o,
  input  wire logic [pcpm_pkg::CH_W-1:0]     channel_i,
  input  wire logic signed [pcpm_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pcpm_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                               result_valid_o,
  output logic      [pcpm_pkg::CH_W-1:0]     out_channel_o,
  output logic      [pcpm_pkg::AVG_W-1:0]    average_o,
  output logic                               no_data_o,
  output logic                               last_o
);

  import pcpm_pkg::*;

  localparam int DEPTH = (MAX_CHANNELS > RES_CAP) ? RES_CAP : MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W = SUM_W + CNT_W;
  localparam logic [10:0]      MAXC    = 11'(MAX_CHANNELS);
  localparam logic [CFG_W-1:0] DEPTH_C = CFG_W'(DEPTH);

  logic [CFG_W-1:0]          cfg_q;
  logic                      any_loaded_q;
  logic [DEPTH-1:0]          valid_q;
  logic [CH_W-1:0]           ch_q;
  logic [SAMPLE_W-1:0]       smp_q;
  logic [AW-1:0]             idx_q;
  logic                      cnt_zero_q;

  logic                      res_valid_q;
  logic [CH_W-1:0]           res_ch_q;
  logic [AVG_W-1:0]          res_avg_q;
  logic                      res_nodata_q;
  logic                      res_last_q;

  logic [ENT_W-1:0]          rdata;
  logic [ENT_W-1:0]          wdata;
  logic [AW-1:0]             raddr;
  logic [AW-1:0]             acc_addr;
  logic                      we;
  logic [SUM_W-1:0]          cur_sum;
  logic [CNT_W-1:0]          cur_cnt;
  logic [SUM_W:0]            sum_add;
  logic [SUM_W-1:0]          sum_new;
  logic [CNT_W-1:0]          cnt_new;
  logic                      ch_ok;
  logic                      positive;
  logic [CFG_W-1:0]          n_act;
  logic [CFG_W-1:0]          last_idx;
  logic                      div_done;
  logic [SUM_W-1:0]          quotient;
  logic [AVG_W-1:0]          avg_cap;

  assign acc_addr = ch_q[AW-1:0];
  assign ch_ok    = ({5'b0, ch_q} < MAXC);
  assign positive = !smp_q[SAMPLE_W-1] && (smp_q != '0);

  // An entry without its valid bit reads as zero.
  always_comb begin
    cur_sum = '0;
    cur_cnt = '0;
    if (cmd_i.acc_write ? valid_q[acc_addr] : valid_q[idx_q]) begin
      cur_sum = rdata[ENT_W-1:CNT_W];
      cur_cnt = rdata[CNT_W-1:0];
    end
  end

  assign sum_add = {1'b0, cur_sum} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, smp_q};
  assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign cnt_new = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;
  assign wdata   = {sum_new, cnt_new};
  assign we      = cmd_i.acc_write && ch_ok && positive;
  assign raddr   = cmd_i.acc_load ? channel_i[AW-1:0] : idx_q;

  pcpm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (acc_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.acc_load || cmd_i.emit_read),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pcpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cur_sum),
    .divisor_i  (cur_cnt),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // A zero setting acts as one channel; large settings clamp to the store.
  always_comb begin
    if (cfg_q == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_q > DEPTH_C) begin
      n_act = DEPTH_C;
    end else begin
      n_act = cfg_q;
    end
  end
  assign last_idx = n_act - 1'b1;

  assign avg_cap = (|quotient[SUM_W-1:AVG_W]) ? {AVG_W{1'b1}} : quotient[AVG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= CFG_W'(1);
      any_loaded_q <= 1'b0;
      valid_q      <= '0;
      res_valid_q  <= 1'b0;
      idx_q        <= '0;
    end else begin
      res_valid_q <= cmd_i.res_load || cmd_i.nodata_load;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.acc_load) begin
        any_loaded_q <= 1'b1;
      end
      if (we) begin
        valid_q[acc_addr] <= 1'b1;
      end
      if (cmd_i.clear_all) begin
        valid_q      <= '0;
        any_loaded_q <= 1'b0;
      end
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      ch_q  <= channel_i;
      smp_q <= sample_i;
    end
    if (cmd_i.div_start) begin
      cnt_zero_q <= (cur_cnt == '0);
    end
    if (cmd_i.res_load) begin
      res_ch_q     <= CH_W'(idx_q);
      res_avg_q    <= cnt_zero_q ? '0 : avg_cap;
      res_nodata_q <= 1'b0;
      res_last_q   <= (idx_q == last_idx[AW-1:0]);
    end else if (cmd_i.nodata_load) begin
      res_ch_q     <= '0;
      res_avg_q    <= '0;
      res_nodata_q <= 1'b1;
      res_last_q   <= 1'b1;
    end
  end

  assign sts_o.any_loaded = any_loaded_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.idx_last   = (idx_q == last_idx[AW-1:0]);

  assign result_valid_o = res_valid_q;
  assign out_channel_o  = res_ch_q;
  assign average_o      = res_avg_q;
  assign no_data_o      = res_nodata_q;
  assign last_o         = res_last_q;

endmodule

`default_nettype wire

/* rtl/pcpm_ctrl.sv */
// Controller state machine: sequences accumulate read-modify-write and
// the per-channel emit run. Depends on pcpm_pkg.
`default_nettype none

module pcpm_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                action_i,
  output logic                     busy_o,
  output pcpm_pkg::pcpm_cmd_t      cmd_o,
  input  wire pcpm_pkg::pcpm_sts_t sts_i
);

  import pcpm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_DIV
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_ACCUM) begin
            cmd_o.acc_load = 1'b1;
            state_d        = ST_ACC;
          end else if (!sts_i.any_loaded) begin
            cmd_o.nodata_load = 1'b1;
          end else begin
            cmd_o.idx_clear = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      ST_ACC: begin
        cmd_o.acc_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_EMIT_DIV;
      end
      ST_EMIT_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.res_load = 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.clear_all = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* verif/per_channel_positive_mean_core_tb.sv */
// Self-checking bench for per_channel_positive_mean_core: directed and
// random command traffic; a scoreboard predicts every per-channel average.
// Depends on pcpm_pkg and the core RTL.
`timescale 1ns / 100ps

module per_channel_positive_mean_core_tb;
  import pcpm_pkg::*;

  localparam int LANES = 64;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [SUM_W-1:0] SUM_TOP = '1;
  localparam logic [AVG_W-1:0] AVG_TOP = '1;
  localparam int SEGMENTS = 12;
  localparam logic [CFG_W-1:0] SEG_CHANNELS [0:SEGMENTS-1] = '{
    7'd0, 7'd3, 7'd64, 7'd5, 7'd127, 7'd1, 7'd9, 7'd65, 7'd2, 7'd16, 7'd4, 7'd6
  };

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [AVG_W-1:0] average;
    logic             no_data;
    logic             last;
  } mean_result_t;

  class mean_tracker;
    logic [SUM_W-1:0] sums [LANES];
    logic [CNT_W-1:0] counts [LANES];
    bit               loaded;
    logic [CFG_W-1:0] channels;
    mean_result_t     due [$];
    int               errors;

    function new();
      clear_stores();
      channels = 7'd1;
      errors = 0;
    endfunction

    function void clear_stores();
      foreach (sums[i]) begin
        sums[i] = '0;
        counts[i] = '0;
      end
      loaded = 1'b0;
    endfunction

    function void set_channels(logic [CFG_W-1:0] value);
      channels = value;
    endfunction

    function int unsigned active();
      if (channels == 0) return 1;
      if (channels > LANES) return LANES;
      return channels;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void note_item(action_e act, logic [CH_W-1:0] ch,
                            logic signed [SAMPLE_W-1:0] smp);
      logic [SUM_W:0]   wide;
      logic [SUM_W-1:0] quot;
      mean_result_t     r;
      int unsigned      n;
      if (act == ACT_ACCUM) begin
        loaded = 1'b1;
        if (smp > 0) begin
          wide = sums[ch] + smp[SAMPLE_W-2:0];
          sums[ch] = (wide > SUM_TOP) ? SUM_TOP : wide[SUM_W-1:0];
          if (counts[ch] != '1) counts[ch]++;
        end
      end else if (!loaded) begin
        r = '{channel: '0, average: '0, no_data: 1'b1, last: 1'b1};
        due.insert(due.size(), r);
      end else begin
        n = active();
        for (int i = 0; i < n; i++) begin
          quot = (counts[i] == 0) ? '0 : sums[i] / counts[i];
          r.channel = CH_W'(i);
          r.average = (quot > AVG_TOP) ? AVG_TOP : quot[AVG_W-1:0];
          r.no_data = 1'b0;
          r.last = (i == n - 1);
          due.insert(due.size(), r);
        end
        clear_stores();
      end
    endfunction

    function void compare_field(string what, logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [CH_W-1:0] ch, logic [AVG_W-1:0] avg,
                               logic nd, logic lst);
      mean_result_t want;
      if (due.size() == 0) begin
        $display("%0t: result with nothing due, expected none, got channel %0d average %0d",
                 $time, ch, avg);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_field("out_channel", want.channel, ch);
      compare_field("average", want.average, avg);
      compare_field("no_data", want.no_data, nd);
      compare_field("last", want.last, lst);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start_i;
  logic                       busy_o;
  logic                       action_i;
  logic [CH_W-1:0]            channel_i;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_W-1:0]           cfg_data_i;
  logic                       result_valid_o;
  logic [CH_W-1:0]            out_channel_o;
  logic [AVG_W-1:0]           average_o;
  logic                       no_data_o;
  logic                       last_o;

  mean_tracker book = new();
  int          sender_idle = 0;
  int          cycles = 0;

  per_channel_positive_mean_core #(
    .MAX_CHANNELS(LANES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .sample_i      (sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .out_channel_o (out_channel_o),
    .average_o     (average_o),
    .no_data_o     (no_data_o),
    .last_o        (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      book.check_result(out_channel_o, average_o, no_data_o, last_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold start high until the command transfers; the caller's next item keeps it up.
  task automatic drive_item(input action_e act, input logic [CH_W-1:0] ch,
                            input logic signed [SAMPLE_W-1:0] smp);
    while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      start_i <= 1'b0;
      action_i <= 1'($urandom);
      channel_i <= CH_W'($urandom);
      sample_i <= SAMPLE_W'($urandom);
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    channel_i <= ch;
    sample_i <= smp;
    do @(posedge clk_i); while (busy_o);
    book.note_item(act, ch, smp);
  endtask

  // Drop start, drain every expected result, then cover a trailing store write.
  task automatic settle();
    start_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_channels(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    book.set_channels(value);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return SAMPLE_W'($urandom_range(1, 255));
      4, 5, 6: return SAMPLE_W'($urandom_range(1, 32767));
      7, 8: return 16'sh8000 | SAMPLE_W'($urandom_range(0, 32767));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CH_W-1:0] pick_channel();
    if ($urandom_range(99) < 85) return CH_W'($urandom_range(0, book.active() - 1));
    return CH_W'($urandom);
  endfunction

  task automatic random_segment(input int items);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(99) < 7) begin
        drive_item(ACT_EMIT, CH_W'($urandom), SAMPLE_W'($urandom));
        // back-to-back emit hits the empty case
        if ($urandom_range(3) == 0) begin
          drive_item(ACT_EMIT, CH_W'($urandom), SAMPLE_W'($urandom));
          k++;
        end
      end else begin
        drive_item(ACT_ACCUM, pick_channel(), pick_sample());
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    action_i <= ACT_ACCUM;
    channel_i <= '0;
    sample_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset register value, empty emit, sign and zero handling.
    drive_item(ACT_EMIT, 6'd0, 16'sh0000);
    drive_item(ACT_ACCUM, 6'd0, 16'sh0100);
    drive_item(ACT_EMIT, 6'd63, 16'shFFFF);
    settle();
    write_channels(7'd4);
    drive_item(ACT_ACCUM, 6'd0, 16'sh7FFF);
    drive_item(ACT_ACCUM, 6'd0, 16'sh0001);
    drive_item(ACT_ACCUM, 6'd1, 16'sh8000);
    drive_item(ACT_ACCUM, 6'd1, 16'sh0000);
    drive_item(ACT_ACCUM, 6'd2, 16'shFFFF);
    drive_item(ACT_ACCUM, 6'd2, 16'sh0003);
    drive_item(ACT_ACCUM, 6'd2, 16'sh0004);
    drive_item(ACT_ACCUM, 6'd63, 16'sh7FFF);
    drive_item(ACT_EMIT, 6'd0, 16'sh0000);
    drive_item(ACT_EMIT, 6'd0, 16'sh0000);
    // negative sample on an unused channel still counts as data
    drive_item(ACT_ACCUM, 6'd5, 16'sh8001);
    drive_item(ACT_EMIT, 6'd0, 16'sh0000);
    drive_item(ACT_ACCUM, 6'd3, 16'sh7FFF);
    drive_item(ACT_ACCUM, 6'd3, 16'sh7FFE);
    drive_item(ACT_EMIT, 6'd0, 16'sh0000);
    settle();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      sender_idle = (seg < 4) ? 37 : (seg < 8) ? 59 : 0;
      write_channels(SEG_CHANNELS[seg]);
      random_segment(28);
      settle();
    end

    repeat (32) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pcpm_pkg.sv
rtl/pcpm_ram.sv
rtl/pcpm_div.sv
rtl/pcpm_datapath.sv
rtl/pcpm_ctrl.sv
rtl/per_channel_positive_mean.sv
verif/per_channel_positive_mean_core_tb.sv
